### sv/lcs_traceback_engine_core_defines.svh
// Assertion macros used by the checker file of the LCS traceback engine.
`ifndef LCS_TRACEBACK_ENGINE_CORE_DEFINES_SVH
`define LCS_TRACEBACK_ENGINE_CORE_DEFINES_SVH
// Concurrent check that holds on every clock edge outside reset.
`define LCS_ASSERT(label, clk_i, rst_ni, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Concurrent check that also holds while reset is asserted.
`define LCS_ASSERT_ALWAYS(label, clk_i, prop, msg) \
	label: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

### sv/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants, move codes and types of the LCS traceback engine.
// ----------------------------------------------------------------------------
`default_nettype none
package lcs_pkg;
	localparam int MaxLenDefault = 64;
	localparam int ScoreW = 7;
	localparam int PosW = 6;

	typedef enum logic [1:0] {
		MV_DIAG = 2'd0,
		MV_UP   = 2'd1,
		MV_LEFT = 2'd2
	} move_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FILL,
		ST_TRACE,
		ST_EMIT,
		ST_DONE
	} state_t;

	// Control carried from the sequencer to the cell chain.
	typedef struct packed {
		logic clear;
		logic step;
	} chain_ctl_t;
endpackage
`default_nettype wire

### sv/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell
// One column of the score wavefront: keeps its second-string byte, score and
// column of moves, takes the first-string byte and left scores from its
// neighbor each cycle that the chain steps.
// ----------------------------------------------------------------------------
`default_nettype none
module lcs_cell #(
	parameter int MAX_LEN = lcs_pkg::MaxLenDefault,
	localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lcs_pkg::chain_ctl_t           ctl,
	input  wire logic                          col_on,
	input  wire logic [7:0]                    col_char,
	input  wire logic [IdxW-1:0]               row,
	input  wire logic [IdxW-1:0]               rd_addr,
	input  wire logic                          in_vld,
	input  wire logic [7:0]                    in_char,
	input  wire logic [lcs_pkg::ScoreW-1:0]    in_left,
	input  wire logic [lcs_pkg::ScoreW-1:0]    in_diag,
	output logic                               out_vld,
	output logic [7:0]                         out_char,
	output logic [lcs_pkg::ScoreW-1:0]         out_left,
	output logic [lcs_pkg::ScoreW-1:0]         out_diag,
	output lcs_pkg::move_t                     rd_move
);
	logic [lcs_pkg::ScoreW-1:0] score_q;
	logic [lcs_pkg::ScoreW-1:0] nxt;
	logic                       vld_q;
	logic [7:0]                 char_q;
	logic [lcs_pkg::ScoreW-1:0] left_q;
	logic [lcs_pkg::ScoreW-1:0] diag_q;
	lcs_pkg::move_t             move;
	lcs_pkg::move_t             move_mem [MAX_LEN];

	always_comb begin
		if (in_char == col_char) begin
			move = lcs_pkg::MV_DIAG;
			nxt  = in_diag + lcs_pkg::ScoreW'(1);
		end else if (score_q >= in_left) begin
			move = lcs_pkg::MV_UP;
			nxt  = score_q;
		end else begin
			move = lcs_pkg::MV_LEFT;
			nxt  = in_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			score_q <= '0;
		end else if (ctl.clear) begin
			vld_q   <= 1'b0;
			score_q <= '0;
		end else if (ctl.step) begin
			vld_q <= in_vld && col_on;
			if (in_vld && col_on) begin
				score_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			char_q <= in_char;
			left_q <= nxt;
			diag_q <= score_q;
		end
	end

	// one move per row of this column, read back during traceback
	always_ff @(posedge clk) begin
		if (ctl.step && in_vld && col_on) begin
			move_mem[row] <= move;
		end
		rd_move <= move_mem[rd_addr];
	end

	assign out_vld  = vld_q;
	assign out_char = char_q;
	assign out_left = left_q;
	assign out_diag = diag_q;
endmodule
`default_nettype wire

### sv/lcs_traceback_engine_core.sv
// ----------------------------------------------------------------------------
// lcs_traceback_engine_core
// LCS of two byte strings with move table fill and traceback.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | request   | valid ready first_char second_char last
// out     | result    | out_valid out_ready position lcs_length empty_res end_of_run
// Loading takes one request per cycle. After last, the cell chain fills the
// move columns as a wavefront, then traceback waits for the registered column
// read before each table step and passes through the emit state per match.
// Results leave through the output register as the sink allows; a stalled
// sink holds the traceback.
// Reset clears control state; stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module lcs_traceback_engine_core #(
	parameter int MAX_LEN = lcs_pkg::MaxLenDefault
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid,
	output logic                            ready,
	input  wire logic [7:0]                 first_char,
	input  wire logic [7:0]                 second_char,
	input  wire logic                       last,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [lcs_pkg::PosW-1:0]        position,
	output logic [lcs_pkg::ScoreW-1:0]      lcs_length,
	output logic                            empty_res,
	output logic                            end_of_run
);
	localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CntW = $clog2(MAX_LEN + 1);
	localparam int StepW = $clog2(2 * MAX_LEN + 2);

	lcs_pkg::state_t state_q, state_d;
	lcs_pkg::chain_ctl_t ctl;

	logic [7:0]       first_mem [MAX_LEN];
	logic [7:0]       second_q  [MAX_LEN];
	logic [CntW-1:0]  cnt_q, n_q;
	logic [StepW-1:0] step_q;
	logic [CntW-1:0]  ti_q, tj_q;
	logic [CntW-1:0]  ti_m1, tj_m1;
	logic             rd_pend_q;
	lcs_pkg::move_t   rd_move;
	logic [IdxW-1:0]  rd_addr;
	logic [lcs_pkg::ScoreW-1:0] total_q;
	logic [CntW-1:0]  found_q;
	logic [7:0]       feed_char;
	logic             emit_go;

	// chain wiring
	logic                       c_vld  [MAX_LEN+1];
	logic [7:0]                 c_char [MAX_LEN+1];
	logic [lcs_pkg::ScoreW-1:0] c_left [MAX_LEN+1];
	logic [lcs_pkg::ScoreW-1:0] c_diag [MAX_LEN+1];
	logic [IdxW-1:0]            c_row  [MAX_LEN];
	lcs_pkg::move_t             c_rd   [MAX_LEN];
	logic [CntW-1:0]            row_q  [MAX_LEN];
	logic [CntW-1:0]            feed_row;
	logic [CntW-1:0]            feed_row_m1;

	// load
	always_ff @(posedge clk) begin
		if (valid && ready && (cnt_q < CntW'(MAX_LEN))) begin
			first_mem[cnt_q[IdxW-1:0]] <= first_char;
			second_q[cnt_q[IdxW-1:0]]  <= second_char;
		end
	end

	// first string feed: registered read, row index follows along the chain
	always_ff @(posedge clk) begin
		feed_char <= first_mem[step_q[IdxW-1:0]];
	end
	assign feed_row    = CntW'(step_q);
	assign feed_row_m1 = feed_row - CntW'(1);

	assign c_vld[0]  = (state_q == lcs_pkg::ST_FILL) && (step_q != '0)
		&& (step_q <= StepW'(n_q));
	assign c_char[0] = feed_char;
	assign c_left[0] = '0;
	assign c_diag[0] = '0;

	// traceback reads one row of every column, then picks the column
	assign ti_m1   = ti_q - CntW'(1);
	assign tj_m1   = tj_q - CntW'(1);
	assign rd_addr = ti_m1[IdxW-1:0];
	assign rd_move = c_rd[tj_m1[IdxW-1:0]];

	for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
		lcs_cell #(.MAX_LEN(MAX_LEN)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.col_on  (CntW'(g) < n_q),
			.col_char(second_q[g]),
			.row     (c_row[g]),
			.rd_addr (rd_addr),
			.in_vld  (c_vld[g]),
			.in_char (c_char[g]),
			.in_left (c_left[g]),
			.in_diag (c_diag[g]),
			.out_vld (c_vld[g+1]),
			.out_char(c_char[g+1]),
			.out_left(c_left[g+1]),
			.out_diag(c_diag[g+1]),
			.rd_move (c_rd[g])
		);
		// row tag travels with the wavefront
		if (g == 0) begin : g_r0
			assign c_row[g] = feed_row_m1[IdxW-1:0];
			always_ff @(posedge clk) if (ctl.step) row_q[g] <= feed_row_m1;
		end else begin : g_rn
			assign c_row[g] = row_q[g-1][IdxW-1:0];
			always_ff @(posedge clk) if (ctl.step) row_q[g] <= row_q[g-1];
		end
	end

	// total length: last cell in row n-1 at column n-1
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_LEN; k++) begin
			if (ctl.step && (CntW'(k) == n_q - CntW'(1)) && c_vld[k+1] &&
				(((k == 0) ? feed_row - CntW'(2) : row_q[k]) == n_q - CntW'(1))) begin
				total_q <= c_left[k+1];
			end
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcs_pkg::ST_LOAD: if (valid && last) state_d = lcs_pkg::ST_FILL;
			lcs_pkg::ST_FILL: if (step_q == StepW'(2 * n_q + 1)) state_d = lcs_pkg::ST_TRACE;
			lcs_pkg::ST_TRACE: if (rd_pend_q && ti_q != '0 && tj_q != '0 &&
				rd_move == lcs_pkg::MV_DIAG) state_d = lcs_pkg::ST_EMIT;
				else if (ti_q == '0 || tj_q == '0) state_d = lcs_pkg::ST_DONE;
			lcs_pkg::ST_EMIT: if (!out_valid || out_ready) state_d = lcs_pkg::ST_TRACE;
			lcs_pkg::ST_DONE: if (!out_valid || out_ready) state_d = lcs_pkg::ST_LOAD;
			default: state_d = lcs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		ctl.clear = (state_q == lcs_pkg::ST_LOAD) && valid && last;
		ctl.step  = (state_q == lcs_pkg::ST_FILL);
		ready     = (state_q == lcs_pkg::ST_LOAD);
	end

	assign emit_go = (!out_valid || out_ready) && ((state_q == lcs_pkg::ST_EMIT) ||
		((state_q == lcs_pkg::ST_DONE) && (found_q == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lcs_pkg::ST_LOAD;
			cnt_q      <= '0;
			n_q        <= '0;
			step_q     <= '0;
			ti_q       <= '0;
			tj_q       <= '0;
			rd_pend_q  <= 1'b0;
			found_q    <= '0;
			out_valid  <= 1'b0;
			position   <= '0;
			lcs_length <= '0;
			empty_res  <= 1'b0;
			end_of_run <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				lcs_pkg::ST_LOAD: begin
					if (valid) begin
						if (last) begin
							n_q    <= (cnt_q < CntW'(MAX_LEN)) ? cnt_q + CntW'(1) : cnt_q;
							cnt_q  <= '0;
							step_q <= '0;
						end else if (cnt_q < CntW'(MAX_LEN)) begin
							cnt_q <= cnt_q + CntW'(1);
						end
					end
				end
				lcs_pkg::ST_FILL: begin
					step_q    <= step_q + StepW'(1);
					ti_q      <= n_q;
					tj_q      <= n_q;
					rd_pend_q <= 1'b0;
					found_q   <= '0;
				end
				lcs_pkg::ST_TRACE: begin
					// wait for the registered move read, then advance
					rd_pend_q <= !rd_pend_q && ti_q != '0 && tj_q != '0;
					if (rd_pend_q) begin
						unique case (rd_move)
							lcs_pkg::MV_DIAG: begin
								ti_q <= ti_q - CntW'(1);
								tj_q <= tj_q - CntW'(1);
							end
							lcs_pkg::MV_LEFT: tj_q <= tj_q - CntW'(1);
							default: ti_q <= ti_q - CntW'(1);
						endcase
					end
				end
				lcs_pkg::ST_EMIT: begin
					if (emit_go) begin
						position   <= lcs_pkg::PosW'(ti_q);
						lcs_length <= total_q;
						empty_res  <= 1'b0;
						found_q    <= found_q + CntW'(1);
						end_of_run <= (found_q + CntW'(1)) == CntW'(total_q);
					end
				end
				lcs_pkg::ST_DONE: begin
					if (emit_go) begin
						position   <= '0;
						lcs_length <= '0;
						empty_res  <= 1'b1;
						end_of_run <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/lcs_traceback_engine_core_checker.sv
// ----------------------------------------------------------------------------
// lcs_traceback_engine_core_checker
// Port-level checks of the LCS traceback engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lcs_traceback_engine_core_defines.svh"
module lcs_traceback_engine_core_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] lcs_length,
	input wire logic       empty_res,
	input wire logic       end_of_run
);
	`LCS_ASSERT(a_empty_eor, clk, arst_n, out_valid && empty_res |-> end_of_run && lcs_length == 7'd0, "empty result must end run")
	`LCS_ASSERT(a_len_pos, clk, arst_n, out_valid && !empty_res |-> lcs_length != 7'd0, "nonempty result needs length")
	`LCS_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(lcs_length), "result dropped")
	`LCS_ASSERT_ALWAYS(a_rst, clk, !arst_n |-> !out_valid, "valid in reset")
endmodule
bind lcs_traceback_engine_core lcs_traceback_engine_core_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.lcs_length(lcs_length), .empty_res(empty_res), .end_of_run(end_of_run)
);
`default_nettype wire

### tb/sv/lcs_traceback_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_traceback_checker
// Watches both channels of the LCS traceback engine, predicts the matched
// positions of each loaded string pair and compares every result field.
// ----------------------------------------------------------------------------
module lcs_traceback_checker #(
	parameter int MAX_LEN = lcs_pkg::MaxLenDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	input  logic                       ready,
	input  logic [7:0]                 first_char,
	input  logic [7:0]                 second_char,
	input  logic                       last,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [lcs_pkg::PosW-1:0]   position,
	input  logic [lcs_pkg::ScoreW-1:0] lcs_length,
	input  logic                       empty_res,
	input  logic                       end_of_run,
	output int                         fail_count,
	output int                         pending_matches
);
	typedef struct packed {
		logic [lcs_pkg::PosW-1:0]   pos;
		logic [lcs_pkg::ScoreW-1:0] len;
		logic                       empty;
		logic                       eor;
	} match_t;

	logic [7:0] str_a [MAX_LEN];
	logic [7:0] str_b [MAX_LEN];
	int         load_cnt;
	match_t     match_q [$];

	assign pending_matches = match_q.size();

	// Fill the score table, then walk back from the corner.
	task automatic predict_matches(input int n);
		logic [lcs_pkg::ScoreW-1:0] score [MAX_LEN+1][MAX_LEN+1];
		lcs_pkg::move_t             mv [MAX_LEN][MAX_LEN];
		logic [lcs_pkg::PosW-1:0]   hits [$];
		int                         i;
		int                         j;
		match_t                     m;
		for (i = 0; i <= n; i++) begin
			score[i][0] = '0;
			score[0][i] = '0;
		end
		for (i = 1; i <= n; i++)
			for (j = 1; j <= n; j++) begin
				if (str_a[i-1] == str_b[j-1]) begin
					score[i][j] = score[i-1][j-1] + 1'b1;
					mv[i-1][j-1] = lcs_pkg::MV_DIAG;
				end else if (score[i-1][j] >= score[i][j-1]) begin
					score[i][j] = score[i-1][j];
					mv[i-1][j-1] = lcs_pkg::MV_UP;
				end else begin
					score[i][j] = score[i][j-1];
					mv[i-1][j-1] = lcs_pkg::MV_LEFT;
				end
			end
		i = n;
		j = n;
		while (i > 0 && j > 0) begin
			case (mv[i-1][j-1])
				lcs_pkg::MV_DIAG: begin
					hits.push_back(lcs_pkg::PosW'(i - 1));
					i--;
					j--;
				end
				lcs_pkg::MV_LEFT: j--;
				default: i--;
			endcase
		end
		if (hits.size() == 0) begin
			m = '{pos: '0, len: '0, empty: 1'b1, eor: 1'b1};
			match_q.push_back(m);
		end else begin
			foreach (hits[k]) begin
				m = '{pos: hits[k], len: score[n][n], empty: 1'b0,
					eor: (k == hits.size() - 1)};
				match_q.push_back(m);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt = 0;
			fail_count = 0;
			match_q.delete();
		end else begin
			if (valid && ready) begin
				if (load_cnt < MAX_LEN) begin
					str_a[load_cnt] = first_char;
					str_b[load_cnt] = second_char;
					load_cnt++;
				end
				if (last) begin
					predict_matches(load_cnt);
					load_cnt = 0;
				end
			end
			if (out_valid && out_ready) begin
				if (match_q.size() == 0) begin
					$error("unexpected result pos=%0d len=%0d", position, lcs_length);
					fail_count++;
				end else begin
					match_t e;
					e = match_q.pop_front();
					if (position !== e.pos) begin
						$error("position: expected %0d actual %0d", e.pos, position);
						fail_count++;
					end
					if (lcs_length !== e.len) begin
						$error("lcs_length: expected %0d actual %0d", e.len, lcs_length);
						fail_count++;
					end
					if (empty_res !== e.empty) begin
						$error("empty_res: expected %0d actual %0d", e.empty, empty_res);
						fail_count++;
					end
					if (end_of_run !== e.eor) begin
						$error("end_of_run: expected %0d actual %0d", e.eor, end_of_run);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

### tb/sv/tb_lcs_traceback_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcs_traceback_engine_core
// Loads string pairs into the LCS traceback engine with random idling and
// back-pressure; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_lcs_traceback_engine_core;
	localparam int MAX_LEN = lcs_pkg::MaxLenDefault;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b1;
	logic                       valid = 1'b0;
	logic                       ready;
	logic [7:0]                 first_char = '0;
	logic [7:0]                 second_char = '0;
	logic                       last = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [lcs_pkg::PosW-1:0]   position;
	logic [lcs_pkg::ScoreW-1:0] lcs_length;
	logic                       empty_res;
	logic                       end_of_run;
	int                         fail_count;
	int                         pending_matches;
	bit                         calm = 1'b0;
	bit                         hold_sink = 1'b0;
	bit                         done = 1'b0;

	always #5 clk = ~clk;

	lcs_traceback_engine_core #(.MAX_LEN(MAX_LEN)) dut (.*);

	lcs_traceback_checker #(.MAX_LEN(MAX_LEN)) chk (.*);

	// Sink side: random stall bursts, or a long hold on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 17);
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one request and hold it until accepted; caller is at a falling edge.
	task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic fin);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		valid <= 1'b1;
		first_char <= a;
		second_char <= b;
		last <= fin;
		do @(posedge clk); while (!ready);
		@(negedge clk);
	endtask

	task automatic send_string(input int n, input int alpha, input bit dup);
		logic [7:0] a;
		logic [7:0] b;
		for (int k = 0; k < n; k++) begin
			a = (alpha == 256) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1));
			b = dup ? a : ((alpha == 256) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1)));
			send_pair(a, b, k == n - 1);
		end
	endtask

	initial begin
		int hold;
		int n;
		#1;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed: single pairs, extremes, no match, full match.
		send_pair(8'h00, 8'h00, 1'b1);
		send_pair(8'hFF, 8'h00, 1'b1);
		send_pair(8'hFF, 8'hFF, 1'b1);
		send_pair(8'hAA, 8'h55, 1'b0);
		send_pair(8'h55, 8'hAA, 1'b1);
		send_pair(8'h01, 8'h02, 1'b0);
		send_pair(8'h02, 8'h01, 1'b0);
		send_pair(8'h03, 8'h03, 1'b1);
		send_string(6, 256, 1'b1);
		send_string(5, 2, 1'b0);
		// Overflow: full length plus ignored pairs, last on an ignored pair.
		for (int k = 0; k < MAX_LEN + 3; k++)
			send_pair(8'($urandom), 8'($urandom_range(0, 3)), k == MAX_LEN + 2);
		send_string(MAX_LEN, 256, 1'b1);
		// Hold the sink long while requests keep coming.
		hold_sink = 1'b1;
		fork
			begin
				hold = 0;
				while (hold < 300) begin
					@(posedge clk);
					hold++;
				end
				hold_sink = 1'b0;
			end
			for (int r = 0; r < 4; r++) send_string(8, 2, 1'b0);
		join
		// Pause until everything has drained.
		valid <= 1'b0;
		while (pending_matches != 0) @(negedge clk);
		// Random: mostly short strings, small alphabets for rich matches.
		for (int r = 0; r < 32; r++) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MAX_LEN)
				: $urandom_range(1, 8);
			if (r == 26) calm = 1'b1;
			case ($urandom_range(0, 3))
				0: send_string(n, 2, 1'b0);
				1: send_string(n, 4, 1'b0);
				2: send_string(n, 256, 1'b0);
				default: send_string(n, 256, 1'($urandom_range(0, 1)));
			endcase
		end
		valid <= 1'b0;
		while (pending_matches != 0) @(negedge clk);
		repeat (4 * MAX_LEN + 20) @(negedge clk);
		done = 1'b1;
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		if (!done) begin
			$display("simulation failed");
			$finish;
		end
	end
endmodule

### lcs_traceback_engine_core.f
+incdir+sv
sv/lcs_pkg.sv
sv/lcs_cell.sv
sv/lcs_traceback_engine_core.sv
sv/lcs_traceback_engine_core_checker.sv
tb/sv/lcs_traceback_checker.sv
tb/sv/tb_lcs_traceback_engine_core.sv
